FILE: hdl/hmb_pkg.sv
// ----------------------------------------------------------------------------
// hmb_pkg
// Shared widths, defaults and register indexes of the histogram-mode
// baseline estimator.
// ----------------------------------------------------------------------------
package hmb_pkg;

  // Default sizes of the histogram and of one bin count.
  localparam int HIST_BINS_DEF   = 1024;
  localparam int MAX_SAMPLES_DEF = 8191;

  // Field widths of the channels.
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 24;
  localparam int FRAC_W   = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 1'd1;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] WINDOW_LOW_RST  = 16'h0000;
  localparam logic [CFG_DATA_W-1:0] WINDOW_HIGH_RST = 16'hFFFF;

endpackage

FILE: hdl/hmb_in_if.sv
// ----------------------------------------------------------------------------
// hmb_in_if
// Sample channel: one ADC sample per item with a flag on the last sample.
// ----------------------------------------------------------------------------
interface hmb_in_if
  import hmb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: hdl/hmb_out_if.sv
// ----------------------------------------------------------------------------
// hmb_out_if
// Result channel: one baseline estimate per trace.
// ----------------------------------------------------------------------------
interface hmb_out_if
  import hmb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] baseline_x256;
  logic             baseline_valid;

  modport source (output valid, output baseline_x256, output baseline_valid, input ready);
  modport sink   (input valid, input baseline_x256, input baseline_valid, output ready);
endinterface

FILE: hdl/histogram_mode_baseline_top.sv
// ----------------------------------------------------------------------------
// histogram_mode_baseline_top
// Histogram-mode baseline estimator: bins the samples of a trace and gives
// the count-weighted mean of the three most recent best bins at trace end.
// ----------------------------------------------------------------------------
// Samples are taken at one item per cycle while a trace is being binned; each
// sample is a read-modify-write of one bin in the histogram memory, and a
// forwarding register covers back-to-back samples that hit the same bin.
// After the item flagged as last sample the input stays stalled through the
// drain state for the last write, the scan with one memory read per bin
// (which also clears the bin), the multiply steps on the shared multiplier,
// the bit-serial divider and the wait until the result register is free. A
// result waiting on the output does not stop binning of the next trace. After
// reset the block zeroes every bin of the memory before it takes its first
// item; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module histogram_mode_baseline_top
  import hmb_pkg::*;
#(
  parameter int HIST_BINS   = HIST_BINS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hmb_in_if.sink                in_ch,
  hmb_out_if.source             out_ch
);

  localparam int IDX_W = $clog2(HIST_BINS);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int TOT_W = CNT_W + 2;
  localparam int PRD_W = IDX_W + CNT_W;
  localparam int WS_W  = PRD_W + 2;
  localparam int NW    = WS_W + FRAC_W;
  localparam int QW    = IDX_W + FRAC_W;
  localparam int DC_W  = $clog2(NW);
  localparam int RES_W = OUT_W + 1;

  localparam logic [IDX_W-1:0]    LAST_ADDR = IDX_W'(HIST_BINS - 1);
  localparam logic [CNT_W-1:0]    CNT_MAX   = CNT_W'(MAX_SAMPLES);
  localparam logic [SAMPLE_W:0]   BIN_LIM   = (SAMPLE_W + 1)'(HIST_BINS);
  localparam logic [DC_W-1:0]     DIV_LAST  = DC_W'(NW - 1);

  typedef enum logic [7:0] {
    ST_CLR   = 8'b0000_0001,
    ST_ACC   = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_TAIL  = 8'b0001_0000,
    ST_MAC   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] win_low_r, win_high_r;

  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [DC_W-1:0]  div_cnt_r, div_cnt_nxt;

  // Histogram memory and its registered read data.
  logic [CNT_W-1:0] hist_mem [HIST_BINS];
  logic [CNT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [CNT_W-1:0] mem_wdata;

  // Binning pipeline.
  logic                in_fire;
  logic [SAMPLE_W-1:0] in_diff;
  logic                in_bin_ok;
  logic [IDX_W-1:0]    in_idx;
  logic                s1_v_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic                hit_r;
  logic [CNT_W-1:0]    fwd_r;
  logic [CNT_W-1:0]    s1_cur, s1_cnt;

  // Scan slots.
  logic             scan_v_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] h0_r, h1_r, h2_r;
  logic [CNT_W-1:0] c0_r, c1_r, c2_r;

  // Weighted sum and division.
  logic [TOT_W-1:0] tot_r;
  logic [WS_W-1:0]  acc_r, mac_sum;
  logic [IDX_W-1:0] h_sel;
  logic [CNT_W-1:0] c_sel;
  logic [PRD_W-1:0] prod;
  logic [NW-1:0]    num_r;
  logic [TOT_W-1:0] rem_r;
  logic [TOT_W:0]   trial;
  logic             trial_ge;
  logic [TOT_W:0]   trial_sub;

  // Result register.
  logic             out_valid_r;
  logic [OUT_W-1:0] out_x256_r;
  logic             out_bvalid_r;
  logic             out_load;
  logic [RES_W-1:0] res_sum;
  logic [OUT_W-1:0] res_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= WINDOW_LOW_RST;
      win_high_r <= WINDOW_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WINDOW_LOW:  win_low_r  <= cfg_wdata;
        CFG_WINDOW_HIGH: win_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input handshake and bin index of the incoming sample.
  assign in_ch.ready = (state_r == ST_ACC);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_diff     = in_ch.sample - win_low_r;
  assign in_bin_ok   = (in_ch.sample > win_low_r) && (in_ch.sample < win_high_r) &&
                       ({1'b0, in_diff} < BIN_LIM);
  assign in_idx      = in_diff[IDX_W-1:0];

  // Increment stage: the previous sample's write lands on the same edge as
  // this sample's read, so a hit on that bin takes the forwarded count.
  assign s1_cur = hit_r ? fwd_r : rd_data_r;
  assign s1_cnt = (s1_cur < CNT_MAX) ? s1_cur + 1'b1 : s1_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire && in_bin_ok;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= in_idx;
    hit_r    <= s1_v_r && (s1_idx_r == in_idx);
    fwd_r    <= s1_cnt;
  end

  // Memory port selection: the clearing pass writes zeros, the scan writes
  // zeros behind its reads, otherwise the increment stage writes back.
  always_comb begin
    case (state_r)
      ST_CLR, ST_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = '0;
      end
      default: begin
        mem_we    = s1_v_r;
        mem_waddr = s1_idx_r;
        mem_wdata = s1_cnt;
      end
    endcase
    mem_raddr = (state_r == ST_SCAN) ? addr_r : in_idx;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= hist_mem[mem_raddr];
  end

  // Scan stage: a strictly larger count pushes the slots down one place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= (state_r == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= addr_r;
    if (state_r == ST_DRAIN) begin
      h0_r <= '0; h1_r <= '0; h2_r <= '0;
      c0_r <= '0; c1_r <= '0; c2_r <= '0;
    end else if (scan_v_r && (rd_data_r > c0_r)) begin
      h2_r <= h1_r;       c2_r <= c1_r;
      h1_r <= h0_r;       c1_r <= c0_r;
      h0_r <= scan_idx_r; c0_r <= rd_data_r;
    end
  end

  // One multiplier shared over the three slots.
  always_comb begin
    case (step_r)
      2'd0: begin
        h_sel = h0_r;
        c_sel = c0_r;
      end
      2'd1: begin
        h_sel = h1_r;
        c_sel = c1_r;
      end
      default: begin
        h_sel = h2_r;
        c_sel = c2_r;
      end
    endcase
  end

  assign prod    = PRD_W'(h_sel) * PRD_W'(c_sel);
  assign mac_sum = acc_r + WS_W'(prod);

  // Restoring divider, one quotient bit a cycle shifted into the numerator.
  assign trial     = {rem_r, num_r[NW-1]};
  assign trial_ge  = (trial >= {1'b0, tot_r});
  assign trial_sub = trial - {1'b0, tot_r};

  always_ff @(posedge clk) begin
    case (state_r)
      ST_TAIL: begin
        acc_r <= '0;
      end
      ST_MAC: begin
        // The last bin reaches the slots on the tail cycle, so the total is
        // formed on the first multiply step.
        if (step_r == 2'd0) begin
          tot_r <= TOT_W'(c0_r) + TOT_W'(c1_r) + TOT_W'(c2_r);
        end
        acc_r <= mac_sum;
        num_r <= {mac_sum, {FRAC_W{1'b0}}};
        rem_r <= '0;
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_sub[TOT_W-1:0] : trial[TOT_W-1:0];
        num_r <= {num_r[NW-2:0], trial_ge};
      end
      default: ;
    endcase
  end

  // Result: quotient plus the window origin, saturated to the field width.
  assign res_sum = RES_W'(num_r[QW-1:0]) + RES_W'({win_low_r, {FRAC_W{1'b0}}});
  assign res_sat = res_sum[OUT_W] ? {OUT_W{1'b1}} : res_sum[OUT_W-1:0];
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bvalid_r <= (c0_r != '0);
      out_x256_r   <= (c0_r != '0) ? res_sat : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.baseline_x256  = out_x256_r;
  assign out_ch.baseline_valid = out_bvalid_r;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    step_nxt    = step_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      ST_CLR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (in_fire && in_ch.last_sample) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        addr_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        step_nxt  = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd2) begin
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end else begin
          state_nxt = ST_MAC;
        end
      end
      ST_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_ACC;
        end
      end
      default: begin
        addr_nxt  = '0;
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      addr_r    <= '0;
      step_r    <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      step_r    <= step_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

FILE: hdl/hmb_checker.sv
// ----------------------------------------------------------------------------
// hmb_checker
// Port-level checks of the baseline estimator, bound to its top level.
// ----------------------------------------------------------------------------
module hmb_checker
  import hmb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last_sample,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_baseline_x256,
  input logic             out_baseline_valid
);

  // The memory clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during the clearing pass after reset");

  // The last item of a trace closes the input for the scan.
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_sample |=> !in_ready)
    else $error("input still open after the last item of a trace");

  // An empty trace reports a zero estimate.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_baseline_valid |-> out_baseline_x256 == '0)
    else $error("invalid result with a non-zero estimate");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_baseline_x256) && $stable(out_baseline_valid))
    else $error("result item changed while stalled");

endmodule

bind histogram_mode_baseline_top hmb_checker u_hmb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_last_sample     (in_ch.last_sample),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_baseline_x256  (out_ch.baseline_x256),
  .out_baseline_valid (out_ch.baseline_valid)
);

FILE: sim/hmb_baseline_monitor.sv
// ----------------------------------------------------------------------------
// hmb_baseline_monitor
// Watches the sample, result and register ports of the histogram-mode
// baseline estimator. It keeps its own histogram and window bounds, works out
// the baseline due at the end of every trace, and compares each result that
// leaves the block with the oldest baseline still awaited.
// ----------------------------------------------------------------------------
module hmb_baseline_monitor
  import hmb_pkg::*;
#(
  parameter int HIST_BINS   = HIST_BINS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hmb_in_if                     in_ch,
  hmb_out_if                    out_ch,
  output int                    fail_count,
  output int                    pending,
  output int                    traces_done,
  output int                    valid_traces
);

  localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam longint unsigned OUT_LIMIT = (64'd1 << OUT_W) - 1;

  typedef struct packed {
    logic [OUT_W-1:0] x256;
    logic             vld;
  } baseline_t;

  // Model state: one count per bin and the two window bounds.
  logic [COUNT_W-1:0]  bin_count [HIST_BINS];
  logic [SAMPLE_W-1:0] win_low;
  logic [SAMPLE_W-1:0] win_high;
  baseline_t           baseline_q [$];
  baseline_t           want;

  initial begin
    fail_count   = 0;
    traces_done  = 0;
    valid_traces = 0;
  end

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned wanted);
    $display("mismatch on trace %0d: %s is %0d, expected %0d",
             traces_done, what, got, wanted);
    fail_count++;
  endtask

  // A sample strictly inside the window and within the histogram adds one to its bin, saturating.
  task automatic bin_sample(input logic [SAMPLE_W-1:0] value);
    logic [SAMPLE_W-1:0] offset;
    if (value > win_low && value < win_high) begin
      offset = value - win_low;
      if (offset < HIST_BINS && bin_count[offset] < MAX_SAMPLES) begin
        bin_count[offset]++;
      end
    end
  endtask

  // Ascending scan keeping the last three bins that beat the best count, then
  // the count-weighted mean height with 8 fraction bits plus the window origin.
  function automatic baseline_t estimate_baseline();
    longint unsigned h0, h1, h2, c0, c1, c2, total, num, est;
    baseline_t       r;
    h0 = 0; h1 = 0; h2 = 0;
    c0 = 0; c1 = 0; c2 = 0;
    for (int b = 0; b < HIST_BINS; b++) begin
      if (bin_count[b] > c0) begin
        h2 = h1; c2 = c1;
        h1 = h0; c1 = c0;
        h0 = b;  c0 = bin_count[b];
      end
    end
    total = c0 + c1 + c2;
    r = '0;
    if (total != 0) begin
      num = (h0 * c0 + h1 * c1 + h2 * c2) << FRAC_W;
      est = num / total + (longint'(win_low) << FRAC_W);
      r.x256 = (est > OUT_LIMIT) ? '1 : est[OUT_W-1:0];
      r.vld  = 1'b1;
    end
    return r;
  endfunction

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bin_count[b]) bin_count[b] = '0;
      win_low  = WINDOW_LOW_RST;
      win_high = WINDOW_HIGH_RST;
      baseline_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WINDOW_LOW:  win_low  = cfg_wdata;
          CFG_WINDOW_HIGH: win_high = cfg_wdata;
          default: ;
        endcase
      end

      // Results leaving the block against the oldest awaited baseline.
      if (out_ch.valid && out_ch.ready) begin
        if (baseline_q.size() == 0) begin
          report_mismatch("result with no trace awaiting one, baseline_x256",
                          out_ch.baseline_x256, 0);
        end else begin
          want = baseline_q.pop_front();
          if (out_ch.baseline_valid !== want.vld) begin
            report_mismatch("baseline_valid", out_ch.baseline_valid, want.vld);
          end
          if (out_ch.baseline_x256 !== want.x256) begin
            report_mismatch("baseline_x256", out_ch.baseline_x256, want.x256);
          end
          traces_done++;
          if (want.vld) valid_traces++;
        end
      end

      // Samples entering the block; the last one closes the trace.
      if (in_ch.valid && in_ch.ready) begin
        bin_sample(in_ch.sample);
        if (in_ch.last_sample) begin
          baseline_q.insert(baseline_q.size(), estimate_baseline());
          foreach (bin_count[b]) bin_count[b] = '0;
        end
      end
    end
    pending <= baseline_q.size();
  end

endmodule

FILE: sim/histogram_mode_baseline_top_tb.sv
// ----------------------------------------------------------------------------
// histogram_mode_baseline_top_tb
// Drives traces of ADC samples into the baseline estimator under a range of
// window settings, with random gaps on the sample side and random stalls on
// the result side. A separate monitor predicts and checks every baseline; this
// module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module histogram_mode_baseline_top_tb;
  import hmb_pkg::*;

  localparam int HIST_BINS    = HIST_BINS_DEF;
  localparam int MAX_SAMPLES  = MAX_SAMPLES_DEF;
  // Idle wait long enough to cover the scan, multiply and divide.
  localparam int DRAIN_CYCLES = HIST_BINS + 64;
  localparam int RANDOM_ITEMS = 1200;
  localparam int RANDOM_PHASES = 12;
  localparam int MIN_TRACES   = 48;
  // Run-length bound for the watchdog, with a wide margin even if every item
  // closed a trace under the longest stalls.
  localparam int CYCLE_LIMIT  = 8_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hmb_in_if  in_ch ();
  hmb_out_if out_ch ();

  int fail_count;
  int pending;
  int traces_done;
  int valid_traces;
  int samples_sent;
  int traces_sent;
  int windows_used;
  int cycle_count;
  int result_gap;
  int ready_hold;
  bit in_quiet;
  bit out_quiet;

  histogram_mode_baseline_top #(
    .HIST_BINS   (HIST_BINS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  hmb_baseline_monitor #(
    .HIST_BINS   (HIST_BINS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) baseline_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .traces_done  (traces_done),
    .valid_traces (valid_traces)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: after each item, hold ready low for a random number of
  // cycles, with occasional runs of no stalls at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if ($urandom_range(0, 4) == 0) out_quiet = ~out_quiet;
      result_gap = out_quiet ? 0 : $urandom_range(0, 6);
      out_ch.ready <= (result_gap == 0);
      ready_hold   <= result_gap;
    end else if (!out_ch.ready) begin
      if (ready_hold <= 1) out_ch.ready <= 1'b1;
      ready_hold <= ready_hold - 1;
    end
  end

  // One sample item, after a random gap with valid low.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= value;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // Wait until every baseline has come out and the block has gone quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both window bounds are written on back-to-back cycles while idle.
  task automatic set_window(input logic [SAMPLE_W-1:0] low,
                            input logic [SAMPLE_W-1:0] high);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WINDOW_LOW;
    cfg_wdata <= low;
    @(posedge clk);
    cfg_idx   <= CFG_WINDOW_HIGH;
    cfg_wdata <= high;
    @(posedge clk);
    cfg_we    <= 1'b0;
    windows_used++;
  endtask

  // A trace clustered around one or two heights inside the window, with some
  // samples at or just above the lower bound and some anywhere in the full range.
  task automatic send_trace(input int low, input int high, input int len);
    int span, reach, main_h, side_h, spread, v, pick;
    span   = high - low;
    reach  = (span > 2) ? ((span - 2 < HIST_BINS + 24) ? span - 2 : HIST_BINS + 24) : 0;
    main_h = low + 1 + $urandom_range(0, reach);
    side_h = low + 1 + $urandom_range(0, reach);
    spread = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) in_quiet = ~in_quiet;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        v = $urandom_range(0, 65535);
      end else if (pick < 3) begin
        v = low + $urandom_range(0, 1);
      end else if (pick < 8) begin
        v = side_h - spread + $urandom_range(0, 2 * spread);
      end else begin
        v = main_h - spread + $urandom_range(0, 2 * spread);
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      send_sample(v[SAMPLE_W-1:0], i == len - 1);
    end
    traces_sent++;
  endtask

  // Main sequence.
  initial begin
    int low, high, phase_items, len;
    samples_sent = 0;
    traces_sent  = 0;
    windows_used = 0;
    in_quiet     = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_WINDOW_LOW;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.sample      <= '0;
    in_ch.last_sample <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: bounds themselves are not counted, so this trace is empty.
    send_sample(16'd0, 1'b0);
    send_sample(16'd65535, 1'b1);
    // Lowest and highest bins in range, one just past the last bin.
    send_sample(16'd1, 1'b0);
    send_sample(16'd1023, 1'b0);
    send_sample(16'd1024, 1'b0);
    send_sample(16'd65534, 1'b1);
    // Rising counts shift the slots down; an equal count does not displace.
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd20, 1'b0);
    for (int i = 0; i < 3; i++) send_sample(16'd30, 1'b0);
    for (int i = 0; i < 3; i++) send_sample(16'd40, i == 2);
    traces_sent += 3;

    // Inverted bounds, then a window with no room between the bounds.
    set_window(16'hFFFF, 16'h0000);
    send_sample(16'd0, 1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd40000, 1'b1);
    set_window(16'd200, 16'd201);
    send_sample(16'd200, 1'b0);
    send_sample(16'd201, 1'b1);
    // Narrowest useful window: a single counted height.
    set_window(16'd100, 16'd102);
    send_sample(16'd100, 1'b0);
    send_sample(16'd101, 1'b0);
    send_sample(16'd102, 1'b1);
    // Top of the sample range, giving the largest baseline.
    set_window(16'd64511, 16'hFFFF);
    send_sample(16'd65534, 1'b0);
    send_sample(16'd65534, 1'b0);
    send_sample(16'd65533, 1'b1);
    traces_sent += 4;

    // A long run on one bin, then a few on another, sent back to back.
    set_window(16'd0, 16'hFFFF);
    in_quiet = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(16'd300, 1'b0);
    for (int i = 0; i < 3; i++) send_sample(16'd600, i == 2);
    in_quiet = 1'b0;
    traces_sent++;

    // Random phases, each under its own window.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin
          low  = $urandom_range(0, 60000);
          high = low + $urandom_range(2, 1300);
        end
        1: begin
          low  = 0;
          high = 65535;
        end
        2: begin
          low  = $urandom_range(64000, 65533);
          high = 65535;
        end
        default: begin
          low  = $urandom_range(0, 65535);
          high = $urandom_range(0, 65535);
        end
      endcase
      set_window(low[SAMPLE_W-1:0], high[SAMPLE_W-1:0]);
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / RANDOM_PHASES ||
             (phase == RANDOM_PHASES - 1 && traces_sent < MIN_TRACES + 13)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        send_trace(low, high, len);
        phase_items += len;
      end
    end

    settle();
    $display("Covered %0d traces (%0d with counted samples) from %0d samples",
             traces_done, valid_traces, samples_sent);
    $display("under %0d window settings, %0d cycles in all.", windows_used + 1,
             cycle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hmb_pkg.sv
hdl/hmb_in_if.sv
hdl/hmb_out_if.sv
hdl/histogram_mode_baseline_top.sv
hdl/hmb_checker.sv
sim/hmb_baseline_monitor.sv
sim/histogram_mode_baseline_top_tb.sv
